>>> design/mrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared widths, codes and controller/datapath link types for the memory
// region table.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int unsigned DEF_MAX_REGIONS = 16;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned HitIdxW = 4;
  localparam int unsigned FilledW = 5;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic load;
    logic add;
    logic scan;
    logic out_load;
  } mrt_cmd_t;

  typedef struct packed {
    logic match;
    logic exhausted;
  } mrt_sts_t;

endpackage

>>> design/mrt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_if
// Valid/ready channels of the memory region table: request and result.
// ----------------------------------------------------------------------------
interface mrt_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [mrt_pkg::AddrW-1:0] region_base;
  logic [mrt_pkg::AddrW-1:0] region_size;
  logic [mrt_pkg::AddrW-1:0] address;

  modport source (output valid, op, region_base, region_size, address, input ready);
  modport sink   (input valid, op, region_base, region_size, address, output ready);
endinterface

interface mrt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        hit;
  logic [mrt_pkg::HitIdxW-1:0] hit_index;
  logic [mrt_pkg::AddrW-1:0]   hit_base;
  logic [mrt_pkg::AddrW-1:0]   hit_size;
  logic [mrt_pkg::AddrW-1:0]   top_address;
  logic [mrt_pkg::FilledW-1:0] filled;

  modport source (output valid, status, hit, hit_index, hit_base, hit_size, top_address,
                  filled, input ready);
  modport sink   (input valid, status, hit, hit_index, hit_base, hit_size, top_address,
                  filled, output ready);
endinterface

>>> design/memory_region_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_region_table
// Table of address regions (base, size) in insertion order: add appends, or
// reports full when no entry is free; lookup returns the first containing
// region; every result carries the highest end address and the fill count.
// ----------------------------------------------------------------------------
//  channel   dir  port   payload
//  request   in   in_i   op, region_base, region_size, address
//  result    out  rsp_o  status, hit, hit_index, hit_base, hit_size,
//                        top_address, filled
//
//  Add: written in the add state if not full. Lookup: the single table read
//  port scans one entry per cycle until a match or the fill count. Either
//  result then enters the output register before a new request is taken.
//  Top address is a running maximum kept at add time. Reset clears the fill
//  count; no clearing pass. A waiting result does not block the next request;
//  a result that finds the output register still full holds until it drains.
// ----------------------------------------------------------------------------
module memory_region_table #(
  parameter int unsigned MAX_REGIONS = mrt_pkg::DEF_MAX_REGIONS
) (
  input logic clk_i,
  input logic rst_ni,
  mrt_in_if.sink    in_i,
  mrt_out_if.source rsp_o
);
  import mrt_pkg::*;

  localparam logic [FilledW-1:0] FullFilled = FilledW'(MAX_REGIONS);

  mrt_cmd_t cmd;
  mrt_sts_t sts;

  mrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_op_i     (in_i.op),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mrt_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .region_base_i (in_i.region_base),
    .region_size_i (in_i.region_size),
    .address_i     (in_i.address),
    .status_o      (rsp_o.status),
    .hit_o         (rsp_o.hit),
    .hit_index_o   (rsp_o.hit_index),
    .hit_base_o    (rsp_o.hit_base),
    .hit_size_o    (rsp_o.hit_size),
    .top_address_o (rsp_o.top_address),
    .filled_o      (rsp_o.filled)
  );

`ifndef SYNTH
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_i.valid && in_i.ready))
    else $error("item loaded without request handshake");

  a_full_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STATUS_FULL) |-> !rsp_o.hit)
    else $error("dropped add reports a hit");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STATUS_FULL) |-> (rsp_o.filled == FullFilled))
    else $error("full status with table not full");

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.hit) |-> (rsp_o.hit_size != '0))
    else $error("hit on a zero-size region");
`endif

endmodule

>>> design/mrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_ctrl
// Sequencer for the region table: takes an item, runs the add or the
// lookup scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mrt_pkg::mrt_sts_t sts_i,
  output mrt_pkg::mrt_cmd_t cmd_o
);
  import mrt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == OP_LOOKUP) ? ST_SCAN : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_FIN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match || sts_i.exhausted) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

>>> design/mrt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_dp
// Region table datapath: base/size memories, fill count, running top
// address, one-read-per-cycle lookup scan and the result registers.
// ----------------------------------------------------------------------------
module mrt_dp #(
  parameter int unsigned MAX_REGIONS = mrt_pkg::DEF_MAX_REGIONS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mrt_pkg::mrt_cmd_t           cmd_i,
  output mrt_pkg::mrt_sts_t           sts_o,
  input  logic [mrt_pkg::AddrW-1:0]   region_base_i,
  input  logic [mrt_pkg::AddrW-1:0]   region_size_i,
  input  logic [mrt_pkg::AddrW-1:0]   address_i,
  output logic                        status_o,
  output logic                        hit_o,
  output logic [mrt_pkg::HitIdxW-1:0] hit_index_o,
  output logic [mrt_pkg::AddrW-1:0]   hit_base_o,
  output logic [mrt_pkg::AddrW-1:0]   hit_size_o,
  output logic [mrt_pkg::AddrW-1:0]   top_address_o,
  output logic [mrt_pkg::FilledW-1:0] filled_o
);
  import mrt_pkg::*;

  localparam int unsigned IdxW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CntW    = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IdxExtW = IdxW + HitIdxW;
  localparam int unsigned CntExtW = CntW + FilledW;

  logic [AddrW-1:0] base_mem [MAX_REGIONS];
  logic [AddrW-1:0] size_mem [MAX_REGIONS];

  logic [AddrW-1:0] rbase_q, rsize_q, addr_q;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [AddrW-1:0] top_q, top_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_idx_q;
  logic [AddrW-1:0] rd_base_q, rd_size_q;

  logic             res_status_q, res_hit_q;
  logic [IdxW-1:0]  res_idx_q;
  logic [AddrW-1:0] res_base_q, res_size_q;

  logic             full, wr_en, rd_issue, contains;
  logic [AddrW-1:0] new_end;
  logic [IdxExtW-1:0] idx_ext;
  logic [CntExtW-1:0] cnt_ext;

  assign full     = (fill_q == CntW'(MAX_REGIONS));
  assign wr_en    = cmd_i.add && !full;
  assign new_end  = rbase_q + rsize_q - AddrW'(1);
  assign rd_issue = cmd_i.scan && (rd_ptr_q != fill_q);
  assign contains = (rd_base_q <= addr_q) && ((addr_q - rd_base_q) < rd_size_q);

  assign sts_o.match     = rd_vld_q && contains;
  assign sts_o.exhausted = !rd_vld_q && (rd_ptr_q == fill_q);

  always_comb begin
    fill_d   = fill_q;
    top_d    = top_q;
    rd_ptr_d = rd_ptr_q;
    rd_vld_d = rd_vld_q;
    if (cmd_i.load) begin
      rd_ptr_d = '0;
      rd_vld_d = 1'b0;
    end
    if (wr_en) begin
      fill_d = fill_q + CntW'(1);
      if (new_end > top_q) begin
        top_d = new_end;
      end
    end
    if (cmd_i.scan) begin
      rd_vld_d = rd_issue;
      if (rd_issue) begin
        rd_ptr_d = rd_ptr_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      top_q    <= '0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      top_q    <= top_d;
      rd_ptr_q <= rd_ptr_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rbase_q <= region_base_i;
      rsize_q <= region_size_i;
      addr_q  <= address_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      base_mem[fill_q[IdxW-1:0]] <= rbase_q;
      size_mem[fill_q[IdxW-1:0]] <= rsize_q;
    end
    if (rd_issue) begin
      rd_base_q <= base_mem[rd_ptr_q[IdxW-1:0]];
      rd_size_q <= size_mem[rd_ptr_q[IdxW-1:0]];
      rd_idx_q  <= rd_ptr_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.add) begin
      res_status_q <= full ? STATUS_FULL : STATUS_OK;
      res_hit_q    <= 1'b0;
      res_idx_q    <= '0;
      res_base_q   <= '0;
      res_size_q   <= '0;
    end else if (cmd_i.scan && sts_o.match) begin
      res_status_q <= STATUS_OK;
      res_hit_q    <= 1'b1;
      res_idx_q    <= rd_idx_q;
      res_base_q   <= rd_base_q;
      res_size_q   <= rd_size_q;
    end else if (cmd_i.scan && sts_o.exhausted) begin
      res_status_q <= STATUS_OK;
      res_hit_q    <= 1'b0;
      res_idx_q    <= '0;
      res_base_q   <= '0;
      res_size_q   <= '0;
    end
  end

  assign idx_ext = IdxExtW'(res_idx_q);
  assign cnt_ext = CntExtW'(fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o      <= res_status_q;
      hit_o         <= res_hit_q;
      hit_index_o   <= idx_ext[HitIdxW-1:0];
      hit_base_o    <= res_base_q;
      hit_size_o    <= res_size_q;
      top_address_o <= top_q;
      filled_o      <= cnt_ext[FilledW-1:0];
    end
  end

endmodule
